### rtl/core/pidc_pkg.sv
// shared types, widths and codes of the two-mode pid controller
`default_nettype none
package pidc_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned ERR_W      = DATA_W + 1;
  localparam int unsigned INTEG_W    = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  // operand widths: first and second error differences
  localparam int unsigned DIFF1_W = ERR_W + 1;
  localparam int unsigned DIFF2_W = ERR_W + 2;
  localparam int unsigned PROD_W  = GAIN_W + DIFF2_W;
  localparam int unsigned ACC_W   = PROD_W + 2;

  typedef logic signed [DATA_W-1:0]     data_t;
  typedef logic signed [GAIN_W-1:0]     gain_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic signed [INTEG_W-1:0]    integ_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic {
    MODE_INCR = 1'b0,
    MODE_POS  = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_GAIN_P = 2'd1,
    CFG_GAIN_I = 2'd2,
    CFG_GAIN_D = 2'd3
  } cfg_reg_e;

  // 32000.0 in q16.16
  localparam data_t  DRIVE_LIMIT = data_t'(32'sd32000 <<< GAIN_FRAC);
  localparam integ_t INTEG_MAX   = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam integ_t INTEG_MIN   = {1'b1, {(INTEG_W-1){1'b0}}};

endpackage
`default_nettype wire

### rtl/core/pidc_in_if.sv
// input channel: operation, setpoint and measurement
`default_nettype none
interface pidc_in_if;
  logic             valid;
  logic             ready;
  pidc_pkg::op_e    operation;
  pidc_pkg::data_t  setpoint;
  pidc_pkg::data_t  measured;

  modport source (output valid, operation, setpoint, measured, input ready);
  modport sink   (input valid, operation, setpoint, measured, output ready);
endinterface
`default_nettype wire

### rtl/core/pidc_out_if.sv
// output channel: clamped drive and limit flag
`default_nettype none
interface pidc_out_if;
  logic             valid;
  logic             ready;
  pidc_pkg::data_t  drive;
  logic             at_limit;

  modport source (output valid, drive, at_limit, input ready);
  modport sink   (input valid, drive, at_limit, output ready);
endinterface
`default_nettype wire

### rtl/core/pid_controller_two_mode.sv
// two-mode pid controller top level: input register, control step, result register
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    operation, setpoint, measured
//   out_o    out  valid/ready    drive, at_limit
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// one item per clock while out_o is not stalled; an item is taken into the input register
// and then moves on to the result register
// the control step is one pass through three gain multipliers and the clamp
// error history, integral and held output update as the item moves to the
// result register, so the next item sees them at once
// reset clears the state, gains and mode (positional); a stalled result
// holds the input register, and in_i.ready is high while that register is empty or advances
`default_nettype none
module pid_controller_two_mode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire pidc_pkg::cfg_idx_t  cfg_idx_i,
  input  wire pidc_pkg::cfg_data_t cfg_data_i,
  pidc_in_if.sink                  in_i,
  pidc_out_if.source               out_o
);
  import pidc_pkg::*;

  // configuration
  mode_e  mode_q;
  gain_t  gain_p_q, gain_i_q, gain_d_q;

  // input register
  logic   in_valid_q;
  op_e    in_op_q;
  data_t  sp_q, ms_q;

  // controller state
  err_t   e1_q, e2_q;
  integ_t integ_q, integ_d;
  data_t  held_q;

  // result register
  logic   out_valid_q;
  data_t  drive_q, drive_d;
  logic   at_limit_q, at_limit_d;

  logic   advance;
  err_t   e0;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.drive = drive_q;
  assign out_o.at_limit = at_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_POS;
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= mode_e'(cfg_data_i[0]);
        CFG_GAIN_P: gain_p_q <= gain_t'(cfg_data_i);
        CFG_GAIN_I: gain_i_q <= gain_t'(cfg_data_i);
        CFG_GAIN_D: gain_d_q <= gain_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q <= in_i.operation;
      sp_q    <= in_i.setpoint;
      ms_q    <= in_i.measured;
    end
  end

  assign e0 = err_t'(sp_q) - err_t'(ms_q);

  // control step
  always_comb begin
    logic signed [DIFF1_W-1:0] d1;
    logic signed [DIFF2_W-1:0] d2;
    prod_t op_p, op_i, op_d;
    prod_t mp, mi, md;
    acc_t  acc, total, isum, lim;

    d1   = DIFF1_W'(e0) - DIFF1_W'(e1_q);
    d2   = DIFF2_W'(e0) - (DIFF2_W'(e1_q) <<< 1) + DIFF2_W'(e2_q);
    op_i = PROD_W'(e0);
    if (mode_q == MODE_POS) begin
      op_p = PROD_W'(e0);
      op_d = PROD_W'(d1);
    end else begin
      op_p = PROD_W'(d1);
      op_d = PROD_W'(d2);
    end
    mp = PROD_W'(gain_p_q) * op_p;
    mi = PROD_W'(gain_i_q) * op_i;
    md = PROD_W'(gain_d_q) * op_d;

    integ_d = integ_q;
    if (mode_q == MODE_POS) begin
      isum = ACC_W'(integ_q) + (ACC_W'(mi) >>> GAIN_FRAC);
      if (isum > ACC_W'(INTEG_MAX)) begin
        integ_d = INTEG_MAX;
      end else if (isum < ACC_W'(INTEG_MIN)) begin
        integ_d = INTEG_MIN;
      end else begin
        integ_d = integ_t'(isum);
      end
      acc   = ACC_W'(mp) + ACC_W'(md);
      total = (acc >>> GAIN_FRAC) + ACC_W'(integ_d);
    end else begin
      isum  = '0;
      acc   = ACC_W'(mp) + ACC_W'(mi) + ACC_W'(md);
      total = ACC_W'(held_q) + (acc >>> GAIN_FRAC);
    end

    // an exact hit on the limit counts as clamped
    lim = ACC_W'(DRIVE_LIMIT);
    if (total >= lim) begin
      drive_d    = DRIVE_LIMIT;
      at_limit_d = 1'b1;
    end else if (total <= -lim) begin
      drive_d    = -DRIVE_LIMIT;
      at_limit_d = 1'b1;
    end else begin
      drive_d    = data_t'(total);
      at_limit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q    <= '0;
      e2_q    <= '0;
      integ_q <= '0;
      held_q  <= '0;
    end else if (advance) begin
      if (in_op_q == OP_CLEAR) begin
        e1_q    <= '0;
        e2_q    <= '0;
        integ_q <= '0;
        held_q  <= '0;
      end else begin
        e1_q    <= e0;
        e2_q    <= e1_q;
        integ_q <= integ_d;
        held_q  <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (in_op_q == OP_CLEAR) begin
        drive_q    <= '0;
        at_limit_q <= 1'b0;
      end else begin
        drive_q    <= drive_d;
        at_limit_q <= at_limit_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_zeroes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_op_q == OP_CLEAR |=> e1_q == '0 && e2_q == '0 && integ_q == '0
      && held_q == '0)
    else $error("clear transfer left controller state non-zero");

  a_held_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> held_q == drive_q)
    else $error("held output differs from the result just produced");

  a_drive_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> drive_q <= DRIVE_LIMIT && drive_q >= -DRIVE_LIMIT)
    else $error("drive beyond the clamp limit");

  a_limit_flag_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && at_limit_q |-> drive_q == DRIVE_LIMIT || drive_q == -DRIVE_LIMIT)
    else $error("limit flag set with drive not at a limit");
`endif

endmodule
`default_nettype wire
